// File: rtl/wbap_pkg.sv
// ----------------------------------------------------------------------------
// wbap_pkg
// Shared constants, widths and types for the weighted budget apportionment
// block and its divider unit.
// ----------------------------------------------------------------------------
package wbap_pkg;

    // Largest number of stages handled; larger requests saturate to this.
    localparam int MAX_STAGES = 16;

    // Fixed port widths.
    localparam int TOT_W     = 16;   // total_count / share
    localparam int SCNT_IN_W = 5;    // num_stages port
    localparam int SIDX_W    = 4;    // stage_index port

    // Internal widths, derived from MAX_STAGES.
    localparam int CNT_W    = $clog2(MAX_STAGES + 1);            // holds 0..MAX_STAGES
    localparam int IDX_W    = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int WT_W     = $clog2(MAX_STAGES + 2);            // weight up to n+1
    localparam int WSUM_MAX = MAX_STAGES * (MAX_STAGES + 3) / 2;
    localparam int WS_W     = $clog2(WSUM_MAX + 1);              // weight sum W
    localparam int PROD_W   = TOT_W + WT_W;                      // T * w
    localparam int DCNT_W   = $clog2(PROD_W + 1);                // divider step count

    // Divider request and response.
    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [WS_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic              busy;
        logic [PROD_W-1:0] quotient;
        logic [WS_W-1:0]   remainder;
    } div_rsp_t;

endpackage

// File: rtl/wbap_div.sv
// ----------------------------------------------------------------------------
// wbap_div
// Restoring divider, one quotient bit per cycle; a start is ignored while busy.
// done pulses for one cycle with quotient and remainder valid.
// ----------------------------------------------------------------------------
module wbap_div
    import wbap_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [WS_W-1:0]   rem_reg, rem_next;
    logic [WS_W-1:0]   dvs_reg, dvs_next;
    logic [WS_W:0]     shifted;
    logic              fits;

    // partial remainder stays below the divisor, so shifted fits WS_W+1 bits
    assign shifted = {rem_reg, quo_reg[PROD_W-1]};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(PROD_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[PROD_W-2:0], fits};
            rem_next = fits ? WS_W'(shifted - {1'b0, dvs_reg}) : shifted[WS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.busy      = busy_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// File: rtl/weighted_budget_apportionment.sv
// ----------------------------------------------------------------------------
// weighted_budget_apportionment
// Splits a total count over n stages by weight, largest remainder first.
// ----------------------------------------------------------------------------
// One input word (total_count T, num_stages n) yields n output words, one
// per stage in index order, the final one flagged by last; n = 0 yields none,
// and n above MAX_STAGES is treated as MAX_STAGES. Stage i has weight n+1-i,
// the weight sum is W = n(n+3)/2, and stage i gets floor(T*w/W) plus one unit
// if its exact remainder T*w mod W ranks among the leftover count (ties go to
// the lower index). The block works on one word at a time and in_ready is
// high only while idle. Per word it runs the set-up, then a multiply and a
// divide per stage in the shared restoring divider (PROD_W = 21, one quotient
// bit per cycle), then for each stage ranks all remainders, one
// remainder-memory read per cycle, and loads the output register. A finished
// word sits in the output register while the block carries on, so the
// downstream side can stall freely.
// ----------------------------------------------------------------------------
module weighted_budget_apportionment
    import wbap_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [TOT_W-1:0]     total_count,
    input  logic [SCNT_IN_W-1:0] num_stages,
    // output channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SIDX_W-1:0]    stage_index,
    output logic [TOT_W-1:0]     share,
    output logic                 last
);

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;  // waiting for a word
    localparam logic [3:0] ST_SETUP = 4'd1;  // weight sum
    localparam logic [3:0] ST_MUL   = 4'd2;  // T * w
    localparam logic [3:0] ST_GO    = 4'd3;  // kick the divider
    localparam logic [3:0] ST_WAIT  = 4'd4;  // divider running
    localparam logic [3:0] ST_LDI   = 4'd5;  // read own remainder
    localparam logic [3:0] ST_LDI2  = 4'd6;  // latch own remainder
    localparam logic [3:0] ST_RANK  = 4'd7;  // sweep all remainders
    localparam logic [3:0] ST_EMIT  = 4'd8;  // load output register

    logic [3:0]         state_reg, state_next;
    logic [TOT_W-1:0]   tot_reg, tot_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [WS_W-1:0]    wsum_reg, wsum_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [IDX_W-1:0]   jd_reg, jd_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [TOT_W-1:0]   sum_reg, sum_next;
    logic [TOT_W-1:0]   left_reg, left_next;
    logic [WS_W-1:0]    cur_rem_reg, cur_rem_next;
    logic [CNT_W-1:0]   rank_reg, rank_next;

    logic               ovld_reg, ovld_next;
    logic [SIDX_W-1:0]  oidx_reg, oidx_next;
    logic [TOT_W-1:0]   oshare_reg, oshare_next;
    logic               olast_reg, olast_next;

    // per-stage storage
    logic [TOT_W-1:0]   base_arr [MAX_STAGES];
    logic [WS_W-1:0]    rem_mem  [MAX_STAGES];
    logic [WS_W-1:0]    rem_rd_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               base_we;
    logic               out_take;

    logic [CNT_W-1:0]   n_sat;
    logic [WT_W-1:0]    weight;
    logic [2*CNT_W+1:0] wprod;
    logic [TOT_W-1:0]   base_rd;

    div_req_t           div_req;
    div_rsp_t           div_rsp;

    wbap_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign out_take = ovld_reg && out_ready;

    // saturate the stage count
    assign n_sat = (32'(num_stages) > MAX_STAGES) ? CNT_W'(MAX_STAGES)
                                                  : CNT_W'(num_stages);

    // weight of stage i is n+1-i; never below 2
    assign weight = WT_W'(n_reg + 1'b1 - i_reg);
    assign wprod  = (2*CNT_W+2)'(n_reg) * (2*CNT_W+2)'(n_reg + 2'd3);

    assign div_req.start    = (state_reg == ST_GO);
    assign div_req.dividend = prod_reg;
    assign div_req.divisor  = wsum_reg;

    // own index in LDI, sweep index otherwise
    assign rd_addr = (state_reg == ST_LDI) ? i_reg[IDX_W-1:0] : j_reg[IDX_W-1:0];
    assign base_we = (state_reg == ST_WAIT) && div_rsp.done;
    assign base_rd = base_arr[i_reg[IDX_W-1:0]];

    always_comb
    begin
        state_next   = state_reg;
        tot_next     = tot_reg;
        n_next       = n_reg;
        wsum_next    = wsum_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        jd_next      = j_reg[IDX_W-1:0];
        rd_vld_next  = 1'b0;
        prod_next    = prod_reg;
        sum_next     = sum_reg;
        left_next    = left_reg;
        cur_rem_next = cur_rem_reg;
        rank_next    = rank_reg;
        ovld_next    = out_take ? 1'b0 : ovld_reg;
        oidx_next    = oidx_reg;
        oshare_next  = oshare_reg;
        olast_next   = olast_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    tot_next = total_count;
                    n_next   = n_sat;
                    if (n_sat != '0)
                    begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                wsum_next  = WS_W'(wprod >> 1);
                i_next     = '0;
                sum_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(tot_reg) * PROD_W'(weight);
                state_next = ST_GO;
            end
            ST_GO:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_rsp.done)
                begin
                    // floor share never exceeds T
                    sum_next = sum_reg + div_rsp.quotient[TOT_W-1:0];
                    i_next   = i_reg + 1'b1;
                    if (i_reg + 1'b1 == n_reg)
                    begin
                        left_next  = tot_reg - sum_next;
                        i_next     = '0;
                        state_next = ST_LDI;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_LDI:
            begin
                state_next = ST_LDI2;
            end
            ST_LDI2:
            begin
                cur_rem_next = rem_rd_reg;
                j_next       = '0;
                rank_next    = '0;
                state_next   = ST_RANK;
            end
            ST_RANK:
            begin
                // issue one read a cycle; compare the word read last cycle
                if (j_reg != n_reg)
                begin
                    rd_vld_next = 1'b1;
                    j_next      = j_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if ((rem_rd_reg > cur_rem_reg) ||
                        ((rem_rd_reg == cur_rem_reg) && (jd_reg < i_reg[IDX_W-1:0])))
                    begin
                        rank_next = rank_reg + 1'b1;
                    end
                end
                else if (j_reg == n_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!ovld_reg || out_ready)
                begin
                    ovld_next   = 1'b1;
                    oidx_next   = SIDX_W'(i_reg);
                    oshare_next = base_rd +
                                  TOT_W'(TOT_W'(rank_reg) < left_reg);
                    olast_next  = (i_reg + 1'b1 == n_reg);
                    i_next      = i_reg + 1'b1;
                    state_next  = (i_reg + 1'b1 == n_reg) ? ST_IDLE : ST_LDI;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd_vld_reg <= 1'b0;
            ovld_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_vld_next;
            ovld_reg   <= ovld_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        tot_reg     <= tot_next;
        n_reg       <= n_next;
        wsum_reg    <= wsum_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        jd_reg      <= jd_next;
        prod_reg    <= prod_next;
        sum_reg     <= sum_next;
        left_reg    <= left_next;
        cur_rem_reg <= cur_rem_next;
        rank_reg    <= rank_next;
        oidx_reg    <= oidx_next;
        oshare_reg  <= oshare_next;
        olast_reg   <= olast_next;
    end

    // floor shares and remainders, one entry per stage
    always_ff @(posedge clk)
    begin
        if (base_we)
        begin
            base_arr[i_reg[IDX_W-1:0]] <= div_rsp.quotient[TOT_W-1:0];
            rem_mem[i_reg[IDX_W-1:0]]  <= div_rsp.remainder;
        end
        rem_rd_reg <= rem_mem[rd_addr];
    end

    assign out_valid   = ovld_reg;
    assign stage_index = oidx_reg;
    assign share       = oshare_reg;
    assign last        = olast_reg;

endmodule

// File: rtl/wbap_chk.sv
// ----------------------------------------------------------------------------
// wbap_chk
// Port-level checks for weighted_budget_apportionment, bound to the top.
// ----------------------------------------------------------------------------
module wbap_chk
    import wbap_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic [TOT_W-1:0]     total_count,
    input logic [SCNT_IN_W-1:0] num_stages,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [SIDX_W-1:0]    stage_index,
    input logic [TOT_W-1:0]     share,
    input logic                 last
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(share) &&
                                    $stable(stage_index) && $stable(last))
        else $error("output word changed while stalled");

    // a word with stages keeps the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (num_stages != '0) |=> !in_ready)
        else $error("ready after accepting a word with stages");

    // zero stages: nothing to do, stay ready
    a_zero_stages: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (num_stages == '0) |=> in_ready)
        else $error("not ready after a zero-stage word");

    // mid-word shares: the block is busy while a non-final stage leaves
    a_busy_mid_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |-> !in_ready)
        else $error("ready before the final stage was sent");

endmodule

bind weighted_budget_apportionment wbap_chk u_wbap_chk (.*);
